[rtl/eth_l4_pkg.sv]
// ----------------------------------------------------------------------------
// eth_l4_pkg
// Types and constants shared by the Ethernet / IPv4 / layer-4 header
// extractor: beat formats, byte offsets, protocol codes and queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eth_l4_pkg;

   localparam int POS_W  = 11;
   localparam int LEN_W  = POS_W + 1;
   localparam int MAXL_W = 11;

   localparam logic [POS_W-1:0]  FRAME_BYTES_LIMIT = 11'd2047;
   localparam logic [MAXL_W-1:0] MAX_FRAME_RESET   = 11'd400;

   // Byte offsets within the frame.
   localparam logic [POS_W-1:0] OFS_ETHER_HI  = 11'd12;
   localparam logic [POS_W-1:0] OFS_ETHER_LO  = 11'd13;
   localparam logic [POS_W-1:0] OFS_PROTO     = 11'd23;
   localparam logic [POS_W-1:0] OFS_SRC_FIRST = 11'd26;
   localparam logic [POS_W-1:0] OFS_SRC_LAST  = 11'd29;
   localparam logic [POS_W-1:0] OFS_DST_FIRST = 11'd30;
   localparam logic [POS_W-1:0] OFS_DST_LAST  = 11'd33;
   localparam logic [POS_W-1:0] OFS_SPORT_HI  = 11'd34;
   localparam logic [POS_W-1:0] OFS_SPORT_LO  = 11'd35;
   localparam logic [POS_W-1:0] OFS_DPORT_HI  = 11'd36;
   localparam logic [POS_W-1:0] OFS_DPORT_LO  = 11'd37;
   localparam logic [POS_W-1:0] OFS_ULEN_HI   = 11'd38;
   localparam logic [POS_W-1:0] OFS_ULEN_LO   = 11'd39;
   localparam logic [POS_W-1:0] OFS_UDP_DATA  = 11'd42;
   localparam logic [POS_W-1:0] OFS_TCP_DOFS  = 11'd46;
   localparam logic [POS_W-1:0] OFS_TCP_DATA  = 11'd47;
   localparam logic [6:0]       L4_BASE       = 7'd34;

   localparam logic [15:0] ETHER_IPV6 = 16'h86DD;
   localparam logic [7:0]  IP_ICMP    = 8'd1;
   localparam logic [7:0]  IP_IGMP    = 8'd2;
   localparam logic [7:0]  IP_TCP     = 8'd6;
   localparam logic [7:0]  IP_UDP     = 8'd17;

   localparam logic [2:0] CLASS_OTHER = 3'd0;
   localparam logic [2:0] CLASS_IPV6  = 3'd1;
   localparam logic [2:0] CLASS_TCP   = 3'd2;
   localparam logic [2:0] CLASS_ICMP  = 3'd3;
   localparam logic [2:0] CLASS_IGMP  = 3'd4;
   localparam logic [2:0] CLASS_UDP   = 3'd5;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_data;
      logic [10:0] payload_offset;
      logic [2:0]  protocol_class;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port_number;
      logic [15:0] destination_port_number;
      logic [15:0] payload_length;
      logic        oversize;
      logic        header_incomplete;
      logic        run_last;
   } rsp_type;

   // Up to two result beats produced by one input beat, packed from first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

[rtl/eth_l4_parser.sv]
// ----------------------------------------------------------------------------
// eth_l4_parser
// Per-frame byte counter and header capture. Each accepted byte updates the
// held header fields and produces up to two result beats: a payload byte
// and, on the last byte, the frame summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eth_l4_parser import eth_l4_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_type           req_item,
   input  wire logic [MAXL_W-1:0] max_len,
   output push_type               push
);

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [15:0]      ether_ff, ether_in;
   logic [7:0]       proto_ff, proto_in;
   logic [31:0]      src_ff,   src_in;
   logic [31:0]      dst_ff,   dst_in;
   logic [15:0]      sport_ff, sport_in;
   logic [15:0]      dport_ff, dport_in;
   logic [5:0]       thb_ff,   thb_in;
   logic [15:0]      ulen_ff,  ulen_in;
   logic             cut_ff,   cut_in;

   logic [7:0]       b;
   logic [LEN_W-1:0] len;
   logic             is_ipv6;
   logic             is_tcp;
   logic             hdr_ipv6;
   logic             hdr_tcp;
   logic [6:0]       hdr_end;
   logic [POS_W-1:0] hdr_end_pos;
   logic [LEN_W-1:0] hdr_end_len;
   logic             emit;
   logic [POS_W-1:0] offset;
   logic [2:0]       class_code;
   logic [15:0]      plen;
   logic             incomplete;
   rsp_type          pay_item;
   rsp_type          sum_item;

   always_comb begin
      b   = req_item.frame_byte;
      len = {1'b0, pos_ff} + LEN_W'(1);

      pos_in   = (pos_ff < FRAME_BYTES_LIMIT) ? pos_ff + POS_W'(1) : pos_ff;
      // A saturated counter means the frame is past every legal length, so
      // the length compare alone covers the overflow case.
      cut_in   = cut_ff | (len > {1'b0, max_len});
      ether_in = ether_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      thb_in   = thb_ff;
      ulen_in  = ulen_ff;

      is_ipv6 = (ether_ff == ETHER_IPV6);
      is_tcp  = !is_ipv6 && (proto_ff == IP_TCP);

      if (pos_ff == OFS_ETHER_HI || pos_ff == OFS_ETHER_LO) begin
         ether_in = {ether_ff[7:0], b};
      end else if (pos_ff == OFS_PROTO) begin
         proto_in = b;
      end else if (pos_ff >= OFS_SRC_FIRST && pos_ff <= OFS_SRC_LAST) begin
         src_in = {src_ff[23:0], b};
      end else if (pos_ff >= OFS_DST_FIRST && pos_ff <= OFS_DST_LAST) begin
         dst_in = {dst_ff[23:0], b};
      end else if (pos_ff == OFS_SPORT_HI || pos_ff == OFS_SPORT_LO) begin
         sport_in = {sport_ff[7:0], b};
      end else if (pos_ff == OFS_DPORT_HI || pos_ff == OFS_DPORT_LO) begin
         dport_in = {dport_ff[7:0], b};
      end else if (!is_tcp && (pos_ff == OFS_ULEN_HI || pos_ff == OFS_ULEN_LO)) begin
         ulen_in = {ulen_ff[7:0], b};
      end else if (is_tcp && pos_ff == OFS_TCP_DOFS) begin
         thb_in = {b[7:4], 2'b00};
      end

      // Emission and the summary see the header as it stands after this byte.
      hdr_ipv6    = (ether_in == ETHER_IPV6);
      hdr_tcp     = !hdr_ipv6 && (proto_in == IP_TCP);
      hdr_end     = L4_BASE + {1'b0, thb_in};
      hdr_end_pos = {4'b0000, hdr_end};
      hdr_end_len = {5'b00000, hdr_end};

      if (hdr_tcp) begin
         emit   = (pos_ff >= OFS_TCP_DATA) && (pos_ff >= hdr_end_pos);
         offset = pos_ff - hdr_end_pos;
      end else begin
         emit   = (pos_ff >= OFS_UDP_DATA);
         offset = pos_ff - OFS_UDP_DATA;
      end

      if (hdr_ipv6) begin
         class_code = CLASS_IPV6;
      end else begin
         case (proto_in)
            IP_TCP:  class_code = CLASS_TCP;
            IP_ICMP: class_code = CLASS_ICMP;
            IP_IGMP: class_code = CLASS_IGMP;
            IP_UDP:  class_code = CLASS_UDP;
            default: class_code = CLASS_OTHER;
         endcase
      end

      if (hdr_tcp) begin
         plen       = (len > hdr_end_len) ? 16'(len - hdr_end_len) : 16'd0;
         incomplete = (len < {1'b0, OFS_TCP_DATA}) || (len < hdr_end_len);
      end else begin
         plen       = ulen_in;
         incomplete = (len < {1'b0, OFS_UDP_DATA});
      end

      pay_item                = '0;
      pay_item.item_kind      = KIND_PAYLOAD;
      pay_item.payload_data   = b;
      pay_item.payload_offset = offset;
      pay_item.run_last       = !req_item.frame_end;

      sum_item                         = '0;
      sum_item.item_kind               = KIND_SUMMARY;
      sum_item.protocol_class          = class_code;
      sum_item.source_address          = src_in;
      sum_item.destination_address     = dst_in;
      sum_item.source_port_number      = sport_in;
      sum_item.destination_port_number = dport_in;
      sum_item.payload_length          = plen;
      sum_item.oversize                = cut_in;
      sum_item.header_incomplete       = incomplete;
      sum_item.run_last                = 1'b1;

      push = '0;
      if (accept) begin
         if (emit && !cut_in) begin
            push.first  = pay_item;
            push.second = sum_item;
            push.count  = req_item.frame_end ? 2'd2 : 2'd1;
         end else begin
            push.first  = sum_item;
            push.second = sum_item;
            push.count  = req_item.frame_end ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_item.frame_end)) begin
         pos_ff   <= '0;
         ether_ff <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
         thb_ff   <= '0;
         ulen_ff  <= '0;
         cut_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         ether_ff <= ether_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         thb_ff   <= thb_in;
         ulen_ff  <= ulen_in;
         cut_ff   <= cut_in;
      end
   end

endmodule

`default_nettype wire

[rtl/eth_l4_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// eth_l4_rsp_fifo
// Small result queue that takes up to two beats per cycle and hands out one
// beat per cycle on the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eth_l4_rsp_fifo import eth_l4_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data,
   output logic          near_full
);

   rsp_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff,  count_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;
   logic                  pop;

   always_comb begin
      pop         = rsp_valid && !rsp_stall;
      wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in   = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in    = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   // Leave room for the two beats that a frame's last byte can produce.
   assign near_full = (count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue holds more beats than its depth");

   a_push_code: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two result beats pushed in one cycle");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      near_full |-> push.count == 2'd0)
      else $error("push into the result queue while it lacks room");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> count_ff == $past(count_ff) - FIFO_CNT_W'(1))
      else $error("result queue count wrong after a pop");
`endif

endmodule

`default_nettype wire

[rtl/eth_ipv4_l4_header_extractor_top.sv]
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_extractor_top
// Ethernet frame byte stream in; payload bytes and one summary per frame out.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+-------------------------------
//   request | req_valid, req_stall, req_data | one frame byte and end mark
//   result  | rsp_valid, rsp_stall, rsp_data | payload byte or frame summary
//   config  | csr_wr_en, csr_wr_data         | maximum frame length
//
// One request beat is taken per cycle while req_stall is low; its results enter
// the result queue at the same edge and can leave from the next cycle on.
// The last byte of a frame can add two beats, so req_stall rises while the
// four-entry result queue holds more than two beats.
// Reset is synchronous; it clears the frame state and sets the maximum frame
// length to 400.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eth_ipv4_l4_header_extractor_top import eth_l4_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [MAXL_W-1:0] csr_wr_data
);

   logic [MAXL_W-1:0] max_len_ff;
   logic              near_full;
   logic              accept;
   push_type          push;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_FRAME_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign req_stall = near_full;
   assign accept    = req_valid && !near_full;

   eth_l4_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_data),
      .max_len  (max_len_ff),
      .push     (push)
   );

   eth_l4_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .near_full (near_full)
   );

`ifndef NO_ASSERTIONS
   a_idle_push: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.count == 2'd0)
      else $error("result beats produced without an accepted byte");

   a_end_summary: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.frame_end) |-> push.count != 2'd0)
      else $error("last byte of a frame produced no summary");

   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_data.frame_end) |-> push.count != 2'd2)
      else $error("summary produced before the last byte of a frame");
`endif

endmodule

`default_nettype wire
